// File: rtl/core/ntsc2_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntsc2_pkg
// Shared types and constants for the two-bit composite video generator.
// ----------------------------------------------------------------------------
package ntsc2_pkg;

  localparam int OVERLAY_COLUMNS_DEF = 512;
  localparam int OVERLAY_ROWS_DEF    = 256;

  localparam int COL_W      = 10;
  localparam int ROW_W      = 9;
  localparam int LINE_W     = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int WORD_BITS  = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_DEPTH   = 4;

  typedef logic [1:0] level_t;
  localparam level_t LVL_SYNC  = 2'h0;
  localparam level_t LVL_BLANK = 2'h2;
  localparam level_t LVL_WHITE = 2'h3;

  // vertical blanking pulse lines
  localparam logic [LINE_W-1:0] VB_SHORT_END = LINE_W'(3);
  localparam logic [LINE_W-1:0] VB_BROAD_END = LINE_W'(6);
  localparam logic [LINE_W-1:0] VB_PULSE_END = LINE_W'(9);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HSYNC       = 3'd0,
    REG_BACK_PORCH  = 3'd1,
    REG_VISIBLE     = 3'd2,
    REG_FRONT_PORCH = 3'd3,
    REG_SAMPLES     = 3'd4,
    REG_LINES       = 3'd5,
    REG_BLANKING    = 3'd6
  } reg_idx_t;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_DRAW = 1'b1
  } op_t;

  typedef enum logic {
    FS_RUN,
    FS_RESYNC
  } fs_t;

  typedef struct packed {
    op_t               op;
    level_t            level;
    logic              use_pixel;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              pixel_on;
    logic              line_end;
    logic              frame_end;
  } cmd_t;

  typedef struct packed {
    level_t level;
    logic   line_end;
    logic   frame_end;
  } out_t;

endpackage
`default_nettype wire

// File: rtl/core/ntsc2_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntsc2 channel interfaces
// Input word channel and video sample channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ntsc2_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [15:0] draw_x;
  logic signed [15:0] draw_y;
  logic               pixel_on;

  modport source (output valid, kind, draw_x, draw_y, pixel_on, input ready);
  modport sink   (input valid, kind, draw_x, draw_y, pixel_on, output ready);
endinterface

interface ntsc2_out_if;
  logic              valid;
  logic              ready;
  ntsc2_pkg::level_t level;
  logic              line_end;
  logic              frame_end;

  modport source (output valid, level, line_end, frame_end, input ready);
  modport sink   (input valid, level, line_end, frame_end, output ready);
endinterface
`default_nettype wire

// File: rtl/core/ntsc2_two_bit_video_generator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntsc_two_bit_video_generator_top
// Two-bit composite video sample generator with a one-bit overlay bitmap.
//
// cmd carries words: kind 0 is a tick that yields one video sample on video,
// kind 1 draws one overlay pixel and yields nothing. The cfg port writes the
// timing registers by index; each write makes cmd.ready drop while the
// half-line position is recomputed from the column (10 steps). A tick goes
// through the queue, address, bitmap read and output buffer stages to video.
// Up to one word per cycle is accepted while cmd.ready is high, ticks and
// draws mixed in any order; the single bitmap port serves one draw or one
// lookup per cycle. After reset the bitmap is cleared one 32-bit word per
// cycle, OVERLAY_COLUMNS * OVERLAY_ROWS / 32 words (4096 by default), and no
// word is accepted until then; timing registers and counters reset at once.
// When video stalls, samples collect in a 4-deep output buffer and then in a
// 4-deep word queue before cmd.ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module ntsc_two_bit_video_generator_top #(
  parameter int OVERLAY_COLUMNS = ntsc2_pkg::OVERLAY_COLUMNS_DEF,
  parameter int OVERLAY_ROWS    = ntsc2_pkg::OVERLAY_ROWS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  ntsc2_in_if.sink                         cmd,
  ntsc2_out_if.source                      video,
  input  logic                             cfg_we,
  input  logic [ntsc2_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ntsc2_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ntsc2_pkg::*;

  cmd_t push_cmd;
  cmd_t head;
  logic push;
  logic pop;
  logic queue_empty;
  logic queue_full;
  logic clearing;

  ntsc2_front #(
    .OVERLAY_COLUMNS (OVERLAY_COLUMNS),
    .OVERLAY_ROWS    (OVERLAY_ROWS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .hold       (clearing),
    .queue_full (queue_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  ntsc2_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (queue_empty),
    .full     (queue_full)
  );

  ntsc2_back #(
    .OVERLAY_COLUMNS (OVERLAY_COLUMNS),
    .OVERLAY_ROWS    (OVERLAY_ROWS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .queue_empty (queue_empty),
    .pop         (pop),
    .clearing    (clearing),
    .video       (video)
  );

endmodule
`default_nettype wire

// File: rtl/core/ntsc2_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntsc2_front
// Accepts words, holds timing registers and counters, classifies each word.
// ----------------------------------------------------------------------------
module ntsc2_front #(
  parameter int OVERLAY_COLUMNS = ntsc2_pkg::OVERLAY_COLUMNS_DEF,
  parameter int OVERLAY_ROWS    = ntsc2_pkg::OVERLAY_ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  ntsc2_in_if.sink                        cmd,
  input  logic                            cfg_we,
  input  logic [ntsc2_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ntsc2_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            hold,
  input  logic                            queue_full,
  output logic                            push,
  output ntsc2_pkg::cmd_t                 push_cmd
);
  import ntsc2_pkg::*;

  logic [7:0]        hsync_length;
  logic [7:0]        back_porch_length;
  logic [9:0]        visible_length;
  logic [7:0]        front_porch_length;
  logic [9:0]        samples_per_line;
  logic [8:0]        lines_per_frame;
  logic [5:0]        blanking_lines;

  logic [10:0]       edge_porch;
  logic [10:0]       edge_vis;
  logic [10:0]       edge_fp;
  logic [4:0]        short_w;
  logic [8:0]        broad_w;
  logic [ROW_W-1:0]  draw_ymax;
  logic signed [10:0] act_m1;

  fs_t               state, state_next;
  logic [COL_W-1:0]  column_count, column_count_next;
  logic [LINE_W-1:0] line_number, line_number_next;
  logic [8:0]        pos, pos_next;
  logic [3:0]        step, step_next;

  logic              accept;
  logic [8:0]        half;
  logic [9:0]        rem_sh;
  logic [10:0]       col_x;
  logic [LINE_W-1:0] line_y;
  logic              active;
  logic              lend;
  logic              fend;
  logic [COL_W-1:0]  dx;
  logic [ROW_W-1:0]  dy;

  assign cmd.ready = (state == FS_RUN) && !queue_full && !hold;
  assign accept    = cmd.valid && cmd.ready;
  assign push      = accept;

  // timing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hsync_length       <= 8'd47;
      back_porch_length  <= 8'd59;
      visible_length     <= 10'd515;
      front_porch_length <= 8'd14;
      samples_per_line   <= 10'd635;
      lines_per_frame    <= 9'd263;
      blanking_lines     <= 6'd20;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HSYNC:       hsync_length       <= cfg_data[7:0];
        REG_BACK_PORCH:  back_porch_length  <= cfg_data[7:0];
        REG_VISIBLE:     visible_length     <= cfg_data;
        REG_FRONT_PORCH: front_porch_length <= cfg_data[7:0];
        REG_SAMPLES:     samples_per_line   <= cfg_data;
        REG_LINES:       lines_per_frame    <= cfg_data[8:0];
        REG_BLANKING:    blanking_lines     <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // derived edges, registered from the timing registers
  assign act_m1 = $signed({2'b00, lines_per_frame}) - $signed({5'b00000, blanking_lines})
                  - 11'sd1;

  always_ff @(posedge clk) begin
    edge_porch <= 11'(hsync_length) + 11'(back_porch_length);
    edge_vis   <= 11'(hsync_length) + 11'(back_porch_length) + 11'(visible_length);
    edge_fp    <= 11'(hsync_length) + 11'(back_porch_length) + 11'(visible_length)
                  + 11'(front_porch_length);
    short_w    <= hsync_length[7:3];
    broad_w    <= (samples_per_line > {3'b000, hsync_length[7:1]}) ?
                  9'((samples_per_line - {3'b000, hsync_length[7:1]}) >> 1) : '0;
    if (act_m1 < 11'sd0)
      draw_ymax <= '0;
    else if (act_m1 > $signed(11'(OVERLAY_ROWS - 1)))
      draw_ymax <= ROW_W'(OVERLAY_ROWS - 1);
    else
      draw_ymax <= ROW_W'(act_m1);
  end

  assign half   = (samples_per_line[9:1] == '0) ? 9'd1 : samples_per_line[9:1];
  assign col_x  = {1'b0, column_count} - edge_porch;
  assign line_y = line_number - LINE_W'(blanking_lines);
  assign active = line_number >= LINE_W'(blanking_lines);
  assign lend   = ({1'b0, column_count} + 11'd1) >= {1'b0, samples_per_line};
  assign fend   = lend && (({1'b0, line_number} + 10'd1) >= {1'b0, lines_per_frame});
  assign rem_sh = {pos, column_count[step]};

  // draw clamps
  always_comb begin
    if (cmd.draw_x[15])
      dx = '0;
    else if (cmd.draw_x[14:0] > 15'(OVERLAY_COLUMNS - 1))
      dx = COL_W'(OVERLAY_COLUMNS - 1);
    else
      dx = cmd.draw_x[COL_W-1:0];
    if (cmd.draw_y[15])
      dy = '0;
    else if (cmd.draw_y[14:0] > 15'(draw_ymax))
      dy = draw_ymax;
    else
      dy = cmd.draw_y[ROW_W-1:0];
  end

  // classify
  always_comb begin
    push_cmd           = '0;
    push_cmd.op        = op_t'(cmd.kind);
    push_cmd.level     = LVL_BLANK;
    push_cmd.use_pixel = 1'b0;
    if (op_t'(cmd.kind) == OP_DRAW) begin
      push_cmd.row      = dy;
      push_cmd.col      = dx;
      push_cmd.pixel_on = cmd.pixel_on;
    end else begin
      push_cmd.row       = line_y;
      push_cmd.col       = col_x[COL_W-1:0];
      push_cmd.line_end  = lend;
      push_cmd.frame_end = fend;
      priority if (!active && (line_number < VB_SHORT_END ||
                   (line_number >= VB_BROAD_END && line_number < VB_PULSE_END))) begin
        push_cmd.level = (pos < 9'(short_w)) ? LVL_SYNC : LVL_BLANK;
      end else if (!active && line_number < VB_BROAD_END) begin
        push_cmd.level = (pos < broad_w) ? LVL_SYNC : LVL_BLANK;
      end else if ({1'b0, column_count} < 11'(hsync_length)) begin
        push_cmd.level = LVL_SYNC;
      end else if ({1'b0, column_count} < edge_porch) begin
        push_cmd.level = LVL_BLANK;
      end else if ({1'b0, column_count} < edge_vis) begin
        push_cmd.level     = LVL_BLANK;
        push_cmd.use_pixel = active && (col_x < 11'(OVERLAY_COLUMNS))
                             && ({1'b0, line_y} < 10'(OVERLAY_ROWS));
      end else if ({1'b0, column_count} < edge_fp) begin
        push_cmd.level = LVL_BLANK;
      end else begin
        push_cmd.level = LVL_SYNC;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= FS_RUN;
      column_count <= '0;
      line_number  <= '0;
      pos          <= '0;
      step         <= '0;
    end else begin
      state        <= state_next;
      column_count <= column_count_next;
      line_number  <= line_number_next;
      pos          <= pos_next;
      step         <= step_next;
    end
  end

  // counters and half-line position; a timing write recomputes the position
  always_comb begin
    state_next        = state;
    column_count_next = column_count;
    line_number_next  = line_number;
    pos_next          = pos;
    step_next         = step;
    if (cfg_we) begin
      state_next = FS_RESYNC;
      step_next  = 4'(COL_W - 1);
      pos_next   = '0;
    end else begin
      unique case (state)
        FS_RUN: begin
          if (accept && op_t'(cmd.kind) == OP_TICK) begin
            if (lend) begin
              column_count_next = '0;
              line_number_next  = fend ? '0 : line_number + 1'b1;
              pos_next          = '0;
            end else begin
              column_count_next = column_count + 1'b1;
              pos_next          = ((pos + 1'b1) == half) ? '0 : pos + 1'b1;
            end
          end
        end
        FS_RESYNC: begin
          if (rem_sh >= {1'b0, half})
            pos_next = 9'(rem_sh - {1'b0, half});
          else
            pos_next = rem_sh[8:0];
          step_next = step - 1'b1;
          if (step == '0)
            state_next = FS_RUN;
        end
        default: state_next = FS_RUN;
      endcase
    end
  end

  a_no_accept_after_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !accept) else $error("word taken right after a timing write");

endmodule
`default_nettype wire

// File: rtl/core/ntsc2_cmd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntsc2_cmd_queue
// Short queue of classified words between the front and back parts.
// ----------------------------------------------------------------------------
module ntsc2_cmd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ntsc2_pkg::cmd_t push_cmd,
  input  logic            pop,
  output ntsc2_pkg::cmd_t head,
  output logic            empty,
  output logic            full
);
  import ntsc2_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CNT_W'(DEPTH));
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push)
      slots[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push)
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)
        count <= count + 1'b1;
      else if (do_pop && !do_push)
        count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/ntsc2_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntsc2_back
// Overlay bitmap memory with clearing pass, pixel lookup and output buffer.
// ----------------------------------------------------------------------------
module ntsc2_back #(
  parameter int OVERLAY_COLUMNS = ntsc2_pkg::OVERLAY_COLUMNS_DEF,
  parameter int OVERLAY_ROWS    = ntsc2_pkg::OVERLAY_ROWS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  ntsc2_pkg::cmd_t head,
  input  logic            queue_empty,
  output logic            pop,
  output logic            clearing,
  ntsc2_out_if.source     video
);
  import ntsc2_pkg::*;

  localparam int BITS   = OVERLAY_COLUMNS * OVERLAY_ROWS;
  localparam int WORDS  = (BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int IDX_W  = $clog2(BITS);
  localparam int BIT_W  = $clog2(WORD_BITS);
  localparam int ADDR_W = IDX_W - BIT_W;
  localparam int PTR_W  = $clog2(OUT_DEPTH);
  localparam int CNT_W  = $clog2(OUT_DEPTH + 1);

  logic [WORD_BITS-1:0] mem [WORDS];
  logic [WORD_BITS-1:0] rdata;
  logic [ADDR_W-1:0]    clr_addr;

  logic                 s1_valid;
  cmd_t                 s1_cmd;
  logic [IDX_W-1:0]     s1_idx;
  logic                 s1_tick;
  logic [ADDR_W-1:0]    s1_word;
  logic [BIT_W-1:0]     s1_bit;

  logic                 s2_valid;
  level_t               s2_level;
  logic                 s2_use_pixel;
  logic [BIT_W-1:0]     s2_bit;
  logic                 s2_line_end;
  logic                 s2_frame_end;

  out_t                 out_mem [OUT_DEPTH];
  out_t                 out_word;
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [CNT_W-1:0]     out_cnt;
  logic [CNT_W:0]       load;
  logic                 out_push;
  logic                 out_pop;

  assign s1_tick = s1_valid && (s1_cmd.op == OP_TICK);
  assign s1_word = s1_idx[IDX_W-1:BIT_W];
  assign s1_bit  = s1_idx[BIT_W-1:0];
  assign load    = (CNT_W+1)'(out_cnt) + (CNT_W+1)'(s1_tick) + (CNT_W+1)'(s2_valid);
  assign pop     = !queue_empty && !clearing && (load < (CNT_W+1)'(OUT_DEPTH));

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ADDR_W'(WORDS - 1))
        clearing <= 1'b0;
    end
  end

  // address stage
  always_ff @(posedge clk) begin
    s1_cmd <= head;
    s1_idx <= IDX_W'(int'(head.row) * OVERLAY_COLUMNS + int'(head.col));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= pop;
      s2_valid <= s1_tick;
    end
  end

  // bitmap access, in word order
  always_ff @(posedge clk) begin
    if (clearing)
      mem[clr_addr] <= '0;
    else if (s1_valid && s1_cmd.op == OP_DRAW)
      mem[s1_word][s1_bit] <= s1_cmd.pixel_on;
    if (s1_tick && s1_cmd.use_pixel)
      rdata <= mem[s1_word];
  end

  always_ff @(posedge clk) begin
    s2_level     <= s1_cmd.level;
    s2_use_pixel <= s1_cmd.use_pixel;
    s2_bit       <= s1_bit;
    s2_line_end  <= s1_cmd.line_end;
    s2_frame_end <= s1_cmd.frame_end;
  end

  always_comb begin
    out_word.level     = s2_use_pixel ? (rdata[s2_bit] ? LVL_WHITE : LVL_BLANK) : s2_level;
    out_word.line_end  = s2_line_end;
    out_word.frame_end = s2_frame_end;
  end

  // output buffer
  assign out_push        = s2_valid;
  assign out_pop         = video.valid && video.ready;
  assign video.valid     = (out_cnt != '0);
  assign video.level     = out_mem[rd_ptr].level;
  assign video.line_end  = out_mem[rd_ptr].line_end;
  assign video.frame_end = out_mem[rd_ptr].frame_end;

  always_ff @(posedge clk) begin
    if (out_push)
      out_mem[wr_ptr] <= out_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      out_cnt <= '0;
    end else begin
      if (out_push)
        wr_ptr <= (wr_ptr == PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (out_pop)
        rd_ptr <= (rd_ptr == PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (out_push && !out_pop)
        out_cnt <= out_cnt + 1'b1;
      else if (out_pop && !out_push)
        out_cnt <= out_cnt - 1'b1;
    end
  end

  a_out_no_overflow: assert property (@(posedge clk) disable iff (rst)
    out_push |-> (out_cnt < CNT_W'(OUT_DEPTH)) || out_pop)
    else $error("output buffer overflow");

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    load <= (CNT_W+1)'(OUT_DEPTH))
    else $error("words in flight exceed output buffer space");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s1_valid && !s2_valid && !out_push)
    else $error("bitmap access during clearing pass");

endmodule
`default_nettype wire
